[rtl/brk_pkg.sv]
// Package for the bit vector rank engine: sizes, command codes, beat types,
// sequencer states and small helper functions. No dependencies.
package brk_pkg;

    // Vector geometry.
    localparam int VECTOR_BITS = 4096;
    localparam int WORD_BITS   = 64;
    localparam int NUM_WORDS   = VECTOR_BITS / WORD_BITS;
    localparam int NUM_BYTES   = VECTOR_BITS / 8;
    localparam int OFF_W       = $clog2(WORD_BITS);
    localparam int POS_W       = $clog2(VECTOR_BITS);
    localparam int WADDR_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W       = $clog2(VECTOR_BITS + 1);
    localparam int POP_W       = OFF_W + 1;

    // Fixed field widths of the beats.
    localparam int CMD_W   = 2;
    localparam int BIDX_W  = 9;
    localparam int BVAL_W  = 8;
    localparam int BITX_W  = 12;
    localparam int RANK_W  = 13;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RANK  = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [WADDR_W-1:0]   waddr_t;
    typedef logic [OFF_W-1:0]     off_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    // Input beat.
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BIDX_W-1:0] byte_index;
        logic [BVAL_W-1:0] byte_value;
        logic [BITX_W-1:0] bit_index;
    } brk_in_t;

    // Result beat.
    typedef struct packed {
        logic              bit_value;
        logic [RANK_W-1:0] rank_count;
    } brk_out_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_HOLD
    } brk_state_t;

    // How the returning word is masked before the popcount.
    typedef enum logic [1:0] {
        MASK_FULL,
        MASK_PREFIX,
        MASK_SINGLE
    } mask_mode_t;

    // Control from the sequencer to the popcount accumulator.
    typedef struct packed {
        logic       clr;
        logic       en;
        mask_mode_t mode;
        off_t       off;
    } acc_ctl_t;

    // Memory request from the sequencer.
    typedef struct packed {
        logic   re;
        waddr_t raddr;
        logic   we;
        waddr_t waddr;
        word_t  wdata;
    } mem_req_t;

    // Word that holds a bit position.
    function automatic waddr_t word_of(pos_t p);
        return WADDR_W'(p >> OFF_W);
    endfunction

    // Bit offset of a position within its word, counted from the msb.
    function automatic off_t offset_of(pos_t p);
        return p[OFF_W-1:0];
    endfunction

    // Field mask for one step of the parallel popcount: bit i is set when
    // bit k of i is clear.
    function automatic word_t swar_mask(int k);
        word_t m;
        m = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            m[i] = ((i >> k) & 1) == 0;
        end
        return m;
    endfunction

endpackage

[rtl/brk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/brk_popacc.sv]
// Shared mask, popcount and accumulate unit of the rank engine.
// Depends on brk_pkg.
module brk_popacc (
    input  logic              aclk,
    input  brk_pkg::acc_ctl_t ctl,
    input  brk_pkg::word_t    word,
    output brk_pkg::cnt_t     acc
);
    import brk_pkg::*;

    word_t        mask;
    word_t        masked;
    word_t        pop_v;
    logic [POP_W-1:0] pop;
    cnt_t         acc_reg;
    cnt_t         acc_next;

    // Mask selection: whole word, prefix up to the offset, or one bit.
    always_comb begin
        case (ctl.mode)
            MASK_PREFIX: mask = ~({WORD_BITS{1'b1}} >> ({1'b0, ctl.off} + POP_W'(1)));
            MASK_SINGLE: mask = {1'b1, {(WORD_BITS-1){1'b0}}} >> ctl.off;
            default:     mask = {WORD_BITS{1'b1}};
        endcase
        masked = word & mask;
    end

    // Parallel popcount, one field-doubling step per stage.
    always_comb begin
        pop_v = masked;
        for (int k = 0; k < OFF_W; k++) begin
            pop_v = (pop_v & swar_mask(k)) + ((pop_v >> (1 << k)) & swar_mask(k));
        end
        pop = pop_v[POP_W-1:0];
    end

    // Accumulator.
    always_comb begin
        acc_next = acc_reg;
        if (ctl.clr) begin
            acc_next = '0;
        end else if (ctl.en) begin
            acc_next = acc_reg + CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

[rtl/brk_ctrl.sv]
// Sequencer of the rank engine: command decode, word address walk, byte
// merge for writes and the result register. Depends on brk_pkg.
module brk_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  brk_pkg::brk_in_t   s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output brk_pkg::brk_out_t  m_item,
    output brk_pkg::mem_req_t  mem_req,
    input  brk_pkg::word_t     mem_rdata,
    output brk_pkg::acc_ctl_t  acc_ctl,
    input  brk_pkg::cnt_t      acc
);
    import brk_pkg::*;

    brk_state_t       state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    pos_t             pos_reg, pos_next;
    logic [BVAL_W-1:0] bval_reg, bval_next;
    waddr_t           addr_reg, addr_next;
    logic             rdv_reg, rdv_next;
    logic             last_reg, last_next;
    logic             m_valid_reg, m_valid_next;
    brk_out_t         m_item_reg, m_item_next;

    logic             accept;
    logic             at_end;
    logic             in_range;
    logic             out_load;
    off_t             byte_sh;
    word_t            merged;

    assign accept   = s_valid && s_ready;
    assign at_end   = (addr_reg == word_of(pos_reg));
    assign out_load = (state_reg == ST_HOLD) && (!m_valid_reg || m_ready);

    // Decide whether the incoming command touches the store at all.
    always_comb begin
        case (s_item.command)
            CMD_WRITE: in_range = 32'(s_item.byte_index) < NUM_BYTES;
            CMD_GET:   in_range = 32'(s_item.bit_index) < VECTOR_BITS;
            CMD_RANK:  in_range = 1'b1;
            default:   in_range = 1'b0;
        endcase
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = in_range ? ST_SCAN : ST_HOLD;
                end
            end
            ST_SCAN: begin
                if (at_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_HOLD;
            ST_HOLD: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Item registers and the word address walk.
    always_comb begin
        cmd_next  = cmd_reg;
        pos_next  = pos_reg;
        bval_next = bval_reg;
        addr_next = addr_reg;
        if (accept) begin
            cmd_next  = s_item.command;
            bval_next = s_item.byte_value;
            if (s_item.command == CMD_WRITE) begin
                pos_next = POS_W'({s_item.byte_index, 3'b000});
            end else if (32'(s_item.bit_index) >= VECTOR_BITS) begin
                pos_next = POS_W'(VECTOR_BITS - 1);
            end else begin
                pos_next = POS_W'(s_item.bit_index);
            end
            addr_next = (s_item.command == CMD_RANK) ? '0 : word_of(pos_next);
        end else if (state_reg == ST_SCAN && !at_end) begin
            addr_next = addr_reg + WADDR_W'(1);
        end
        rdv_next  = (state_reg == ST_SCAN);
        last_next = (state_reg == ST_SCAN) && at_end;
    end

    // Byte merge for a write: the byte's msb sits at the lowest bit position.
    always_comb begin
        byte_sh = OFF_W'(WORD_BITS - 8) - offset_of(pos_reg);
        merged  = (mem_rdata & ~(word_t'(8'hFF) << byte_sh))
                | (word_t'(bval_reg) << byte_sh);
    end

    // Result register; a new item can be taken while a result waits.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (out_load) begin
            m_valid_next           = 1'b1;
            m_item_next.bit_value  = (cmd_reg == CMD_GET) ? acc[0] : 1'b0;
            m_item_next.rank_count = (cmd_reg == CMD_RANK) ? RANK_W'(acc) : '0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Outputs of the sequencer.
    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        mem_req.re    = (state_reg == ST_SCAN);
        mem_req.raddr = addr_reg;
        mem_req.we    = (state_reg == ST_DRAIN) && (cmd_reg == CMD_WRITE);
        mem_req.waddr = addr_reg;
        mem_req.wdata = merged;
        acc_ctl.clr   = accept;
        acc_ctl.en    = rdv_reg && (cmd_reg != CMD_WRITE);
        acc_ctl.off   = offset_of(pos_reg);
        if (cmd_reg == CMD_GET) begin
            acc_ctl.mode = MASK_SINGLE;
        end else if (last_reg) begin
            acc_ctl.mode = MASK_PREFIX;
        end else begin
            acc_ctl.mode = MASK_FULL;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rdv_reg     <= 1'b0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rdv_reg     <= rdv_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        bval_reg   <= bval_next;
        addr_reg   <= addr_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

[rtl/bitvector_rank_engine_top.sv]
// Top level of the bit vector rank engine.
// Depends on brk_pkg, brk_ctrl, brk_popacc and brk_ram.
//
// The engine holds a 4096-bit vector in a 64 x 64-bit RAM, loaded one byte
// per write beat (bit 0 is the msb of byte 0), and answers get and rank
// beats with one result beat each; every command, including writes and the
// unused code, returns exactly one result. The block takes one command at a
// time: a write or a get reads its word, then merges or popcounts it, then
// loads the result, and a rank over bit index p reads words 0 to p/64 in
// turn through the single RAM read port, which returns one stored word per
// cycle into the shared popcount accumulator, before its result loads. The
// engine is ready again in the cycle after the result loads. The result sits
// in an output register, so the next command is accepted while it waits.
// There is no clearing pass after reset; reading a byte that was never
// written gives an unspecified answer.
module bitvector_rank_engine_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  brk_pkg::brk_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output brk_pkg::brk_out_t m_item
);
    import brk_pkg::*;

    mem_req_t mem_req;
    word_t    mem_rdata;
    acc_ctl_t acc_ctl;
    cnt_t     acc;

    // Command sequencer and result register.
    brk_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .acc_ctl   (acc_ctl),
        .acc       (acc)
    );

    // Word store.
    brk_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    // Shared popcount accumulator.
    brk_popacc u_popacc (
        .aclk (aclk),
        .ctl  (acc_ctl),
        .word (mem_rdata),
        .acc  (acc)
    );

endmodule

[rtl/brk_checker.sv]
// Port-level checker for the bit vector rank engine and its bind.
// Depends on brk_pkg and bitvector_rank_engine_top.
module brk_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input brk_pkg::brk_in_t  s_item,
    input logic              m_valid,
    input logic              m_ready,
    input brk_pkg::brk_out_t m_item
);
    import brk_pkg::*;

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result beat changed while stalled");

    // Only one command is in work at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a command is in work");

    // The engine becomes ready again only as it presents a result.
    a_ready_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(s_ready) |-> m_valid)
        else $error("ready returned without a result beat");

    // A result never carries both a bit and a count.
    a_one_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.bit_value && (m_item.rank_count != '0)))
        else $error("bit value and rank count both set");

    // A rank can never exceed the vector length.
    a_rank_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_item.rank_count) <= VECTOR_BITS)
        else $error("rank count beyond vector length");

endmodule

bind bitvector_rank_engine_top brk_checker u_brk_checker (.*);
